@@ hdl/rsi_pkg.sv @@
`timescale 1ns / 1ps

package rsi_pkg;

    // Width of half_b, Q.30 signed
    localparam int HB_W  = 51;
    // Root bits, radicand bits and partial remainder bits of the square root
    localparam int SQ_NB = 51;
    localparam int RAD_W = 2 * SQ_NB;
    localparam int REM_W = SQ_NB + 2;
    // Distance in Q22.16 before saturation
    localparam int T16_W = 38;

    typedef enum logic [1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_CENTER_Z,
        CFG_RADIUS_SQUARED
    } cfg_index_e;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        hit_distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               maybe_hit;
    } result_t;

    // Data that rides along the square root chain
    typedef struct packed {
        ray_t                   ray;
        logic signed [HB_W-1:0] hb;
        logic                   neg;
        logic                   maybe;
    } carry_t;

endpackage

@@ hdl/rsi_front.sv @@
`timescale 1ns / 1ps

module rsi_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        ray_valid,
    input  rsi_pkg::ray_t               ray,
    input  logic signed [31:0]          center_x,
    input  logic signed [31:0]          center_y,
    input  logic signed [31:0]          center_z,
    input  logic [62:0]                 radius_squared,
    output logic                        out_valid,
    output rsi_pkg::carry_t             carry,
    output logic [rsi_pkg::RAD_W-1:0]   rad
);
    import rsi_pkg::*;

    function automatic logic [49:0] mag51(input logic signed [50:0] v);
        logic signed [50:0] n;
        n = v[50] ? -v : v;
        return n[49:0];
    endfunction

    logic [6:0] valid_reg;

    logic signed [31:0] cen [3];
    logic signed [31:0] st  [3];
    logic signed [15:0] d1  [3];

    // stage 1
    ray_t               ray1_reg;
    logic signed [32:0] o1_reg  [3];
    logic signed [32:0] o1_next [3];
    // stage 2
    ray_t               ray2_reg;
    logic signed [48:0] dot2_reg [3];
    logic signed [48:0] cpa2_reg [3];
    logic signed [48:0] cpb2_reg [3];
    logic signed [65:0] sq2_reg  [3];
    // stage 3
    ray_t               ray3_reg;
    logic signed [50:0] hb3_reg;
    logic signed [50:0] hb3_next;
    logic signed [49:0] c3_reg  [3];
    logic signed [49:0] c3_next [3];
    logic [66:0]        oo3;
    logic               inside3_reg;
    logic signed [67:0] om3_reg;
    // stage 4
    ray_t               ray4_reg;
    logic signed [50:0] hb4_reg;
    logic signed [67:0] om4_reg;
    logic               inside4_reg;
    logic [49:0]        m4_reg  [4];
    logic [49:0]        m4_next [4];
    // stage 5
    ray_t               ray5_reg;
    logic signed [50:0] hb5_reg;
    logic signed [67:0] om5_reg;
    logic               inside5_reg;
    logic [49:0]        hh5_reg [4];
    logic [49:0]        hl5_reg [4];
    logic [49:0]        ll5_reg [4];
    // stage 6
    ray_t               ray6_reg;
    logic signed [50:0] hb6_reg;
    logic signed [67:0] om6_reg;
    logic               inside6_reg;
    logic [99:0]        sq6_reg  [4];
    logic [99:0]        sq6_next [4];
    // stage 7
    logic [101:0]        qd7;
    logic signed [103:0] disc7;
    logic                hb_pos7;
    carry_t              carry_reg;
    carry_t              carry_next;
    logic [RAD_W-1:0]    rad_reg;
    logic [RAD_W-1:0]    rad_next;

    // advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], ray_valid};
        end
    end

    // offset from ray start to sphere centre
    always_comb
    begin
        cen[0] = center_x;
        cen[1] = center_y;
        cen[2] = center_z;
        st[0]  = ray.start_x;
        st[1]  = ray.start_y;
        st[2]  = ray.start_z;
        d1[0]  = ray1_reg.dir_x;
        d1[1]  = ray1_reg.dir_y;
        d1[2]  = ray1_reg.dir_z;
        for (int i = 0; i < 3; i++)
        begin
            o1_next[i] = $signed({cen[i][31], cen[i]}) - $signed({st[i][31], st[i]});
        end
    end

    // sum dot product and cross terms, squared offset length
    always_comb
    begin
        hb3_next = $signed({{2{dot2_reg[0][48]}}, dot2_reg[0]})
                 + $signed({{2{dot2_reg[1][48]}}, dot2_reg[1]})
                 + $signed({{2{dot2_reg[2][48]}}, dot2_reg[2]});
        for (int i = 0; i < 3; i++)
        begin
            c3_next[i] = $signed({cpa2_reg[i][48], cpa2_reg[i]})
                       - $signed({cpb2_reg[i][48], cpb2_reg[i]});
        end
        oo3 = {2'b00, sq2_reg[0][64:0]} + {2'b00, sq2_reg[1][64:0]}
            + {2'b00, sq2_reg[2][64:0]};
    end

    // magnitudes and assembled squares
    always_comb
    begin
        m4_next[0] = mag51(hb3_reg);
        for (int i = 0; i < 3; i++)
        begin
            m4_next[i+1] = mag51($signed({c3_reg[i][49], c3_reg[i]}));
        end
        for (int j = 0; j < 4; j++)
        begin
            sq6_next[j] = {hh5_reg[j], 50'd0} + {24'd0, hl5_reg[j], 26'd0}
                        + {50'd0, ll5_reg[j]};
        end
    end

    // discriminant and prefilter
    always_comb
    begin
        qd7 = {2'b00, sq6_reg[1]} + {2'b00, sq6_reg[2]} + {2'b00, sq6_reg[3]};
        disc7 = $signed({4'd0, sq6_reg[0]})
              - $signed({{8{om6_reg[67]}}, om6_reg, 28'd0});
        hb_pos7 = !hb6_reg[50] && (hb6_reg != '0);
        carry_next.ray   = ray6_reg;
        carry_next.hb    = hb6_reg;
        carry_next.neg   = disc7[103];
        carry_next.maybe = ({11'd0, radius_squared, 28'd0} >= qd7)
                         && (hb_pos7 || inside6_reg);
        rad_next = disc7[103] ? '0 : disc7[RAD_W-1:0];
    end

    // hold payload and register stage results through the front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray1_reg <= ray;
            o1_reg   <= o1_next;

            ray2_reg <= ray1_reg;
            for (int i = 0; i < 3; i++)
            begin
                dot2_reg[i] <= o1_reg[i] * d1[i];
                sq2_reg[i]  <= o1_reg[i] * o1_reg[i];
            end
            cpa2_reg[0] <= d1[1] * o1_reg[2];
            cpb2_reg[0] <= d1[2] * o1_reg[1];
            cpa2_reg[1] <= d1[2] * o1_reg[0];
            cpb2_reg[1] <= d1[0] * o1_reg[2];
            cpa2_reg[2] <= d1[0] * o1_reg[1];
            cpb2_reg[2] <= d1[1] * o1_reg[0];

            ray3_reg    <= ray2_reg;
            hb3_reg     <= hb3_next;
            c3_reg      <= c3_next;
            inside3_reg <= ({4'd0, radius_squared} > oo3);
            om3_reg     <= $signed({1'b0, oo3}) - $signed({5'd0, radius_squared});

            ray4_reg    <= ray3_reg;
            hb4_reg     <= hb3_reg;
            om4_reg     <= om3_reg;
            inside4_reg <= inside3_reg;
            m4_reg      <= m4_next;

            ray5_reg    <= ray4_reg;
            hb5_reg     <= hb4_reg;
            om5_reg     <= om4_reg;
            inside5_reg <= inside4_reg;
            for (int j = 0; j < 4; j++)
            begin
                hh5_reg[j] <= m4_reg[j][49:25] * m4_reg[j][49:25];
                hl5_reg[j] <= m4_reg[j][49:25] * m4_reg[j][24:0];
                ll5_reg[j] <= m4_reg[j][24:0] * m4_reg[j][24:0];
            end

            ray6_reg    <= ray5_reg;
            hb6_reg     <= hb5_reg;
            om6_reg     <= om5_reg;
            inside6_reg <= inside5_reg;
            sq6_reg     <= sq6_next;

            carry_reg <= carry_next;
            rad_reg   <= rad_next;
        end
    end

    assign out_valid = valid_reg[6];
    assign carry     = carry_reg;
    assign rad       = rad_reg;

endmodule

@@ hdl/rsi_sqrt_cell.sv @@
`timescale 1ns / 1ps

module rsi_sqrt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  rsi_pkg::carry_t             in_carry,
    input  logic [rsi_pkg::RAD_W-1:0]   in_rad,
    input  logic [rsi_pkg::REM_W-1:0]   in_rem,
    input  logic [rsi_pkg::SQ_NB-1:0]   in_root,
    output logic                        out_valid,
    output rsi_pkg::carry_t             out_carry,
    output logic [rsi_pkg::RAD_W-1:0]   out_rad,
    output logic [rsi_pkg::REM_W-1:0]   out_rem,
    output logic [rsi_pkg::SQ_NB-1:0]   out_root
);
    import rsi_pkg::*;

    logic             valid_reg;
    carry_t           carry_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [RAD_W-1:0] rad_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [SQ_NB-1:0] root_reg;
    logic [SQ_NB-1:0] root_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one root bit: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh    = {in_rem[REM_W-3:0], in_rad[RAD_W-1:RAD_W-2]};
        trial     = {in_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {in_root[SQ_NB-2:0], ge};
        rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg <= in_carry;
            rad_reg   <= rad_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_carry = carry_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

@@ hdl/ray_sphere_intersect_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Beat
// ray       in         ray_valid / ray_stall     start point and direction
// result    out        result_valid / result_stall  hit, distance, point, prefilter
// cfg       in         cfg_valid / cfg_ready     register index and data
//
// One ray enters per cycle while ray_stall is low; a result passes through 7 setup
// stages, a chain of 51 square root cells (one root bit each), 2 root/point stages
// and a 2-beat output buffer.
// Reset clears the stage valid bits, the buffer count and pointers and the sphere registers.
// The whole pipeline freezes only while the output buffer holds two beats.

module ray_sphere_intersect_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ray_valid,
    output logic              ray_stall,
    input  rsi_pkg::ray_t     ray,
    output logic              result_valid,
    input  logic              result_stall,
    output rsi_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [62:0]       cfg_data
);
    import rsi_pkg::*;

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [62:0]        radius_squared_reg;

    logic en;

    logic             v_w     [SQ_NB+1];
    carry_t           carry_w [SQ_NB+1];
    logic [RAD_W-1:0] rad_w   [SQ_NB+1];
    logic [REM_W-1:0] rem_w   [SQ_NB+1];
    logic [SQ_NB-1:0] root_w  [SQ_NB+1];

    carry_t             cq;
    logic signed [52:0] t1;
    logic signed [52:0] t2;
    logic signed [52:0] t30;
    logic               hit_b1_next;

    logic               b1_valid_reg;
    carry_t             b1_carry_reg;
    logic               b1_hit_reg;
    logic [T16_W-1:0]   b1_t16_reg;

    logic               b2_valid_reg;
    carry_t             b2_carry_reg;
    logic               b2_hit_reg;
    logic [30:0]        b2_hd_reg;
    logic signed [54:0] b2_prod_reg [3];
    logic signed [15:0] b1_dir [3];
    logic signed [31:0] b2_start [3];
    logic signed [41:0] psum [3];
    logic signed [31:0] psat [3];
    result_t            res_next;

    result_t     ent_reg [2];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;

    // sphere registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            center_z_reg       <= '0;
            radius_squared_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:       center_x_reg       <= cfg_data[31:0];
                CFG_CENTER_Y:       center_y_reg       <= cfg_data[31:0];
                CFG_CENTER_Z:       center_z_reg       <= cfg_data[31:0];
                CFG_RADIUS_SQUARED: radius_squared_reg <= cfg_data;
            endcase
        end
    end

    // freeze the pipeline only when the output buffer is full
    assign en        = (cnt_reg != 2'd2);
    assign ray_stall = !en;

    rsi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .ray_valid      (ray_valid),
        .ray            (ray),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .center_z       (center_z_reg),
        .radius_squared (radius_squared_reg),
        .out_valid      (v_w[0]),
        .carry          (carry_w[0]),
        .rad            (rad_w[0])
    );

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;

    // square root chain, one root bit per cell
    for (genvar k = 0; k < SQ_NB; k++)
    begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_w[k]),
            .in_carry  (carry_w[k]),
            .in_rad    (rad_w[k]),
            .in_rem    (rem_w[k]),
            .in_root   (root_w[k]),
            .out_valid (v_w[k+1]),
            .out_carry (carry_w[k+1]),
            .out_rad   (rad_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_root  (root_w[k+1])
        );
    end

    // pick the smaller non-negative root
    always_comb
    begin
        cq  = carry_w[SQ_NB];
        t1  = $signed({{2{cq.hb[HB_W-1]}}, cq.hb}) - $signed({2'b00, root_w[SQ_NB]});
        t2  = $signed({{2{cq.hb[HB_W-1]}}, cq.hb}) + $signed({2'b00, root_w[SQ_NB]});
        hit_b1_next = !cq.neg && (!t1[52] || !t2[52]);
        t30 = !t1[52] ? t1 : t2;
        b1_dir[0] = b1_carry_reg.ray.dir_x;
        b1_dir[1] = b1_carry_reg.ray.dir_y;
        b1_dir[2] = b1_carry_reg.ray.dir_z;
    end

    // hit point, saturated; point and distance zero when no hit
    always_comb
    begin
        b2_start[0] = b2_carry_reg.ray.start_x;
        b2_start[1] = b2_carry_reg.ray.start_y;
        b2_start[2] = b2_carry_reg.ray.start_z;
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = $signed({{10{b2_start[i][31]}}, b2_start[i]})
                    + $signed({b2_prod_reg[i][54], b2_prod_reg[i][54:14]});
            if ((psum[i][41:31] == '0) || (psum[i][41:31] == '1))
            begin
                psat[i] = psum[i][31:0];
            end
            else if (psum[i][41])
            begin
                psat[i] = 32'sh8000_0000;
            end
            else
            begin
                psat[i] = 32'sh7FFF_FFFF;
            end
        end
        res_next.hit          = b2_hit_reg;
        res_next.hit_distance = b2_hit_reg ? b2_hd_reg : '0;
        res_next.point_x      = b2_hit_reg ? psat[0] : '0;
        res_next.point_y      = b2_hit_reg ? psat[1] : '0;
        res_next.point_z      = b2_hit_reg ? psat[2] : '0;
        res_next.maybe_hit    = b2_carry_reg.maybe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= v_w[SQ_NB];
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_carry_reg <= cq;
            b1_hit_reg   <= hit_b1_next;
            b1_t16_reg   <= t30[51:14];

            b2_carry_reg <= b1_carry_reg;
            b2_hit_reg   <= b1_hit_reg;
            b2_hd_reg    <= (b1_t16_reg[T16_W-1:31] != '0) ? 31'h7FFF_FFFF
                                                           : b1_t16_reg[30:0];
            for (int i = 0; i < 3; i++)
            begin
                b2_prod_reg[i] <= $signed({1'b0, b1_t16_reg}) * b1_dir[i];
            end
        end
    end

    // two-beat output buffer
    assign push = en && b2_valid_reg;
    assign pop  = result_valid && !result_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= res_next;
        end
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = ent_reg[rd_ptr_reg];

endmodule
